### rtl/integer_affine_transform_defines.svh
// Assertion macros shared by the integer affine transform RTL.
`ifndef INTEGER_AFFINE_TRANSFORM_DEFINES_SVH
`define INTEGER_AFFINE_TRANSFORM_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define IAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define IAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IAT_ASSERT_NOW(lbl, ante, cons, msg)
`define IAT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/iat_pkg.sv
// Types, codes and helpers for the integer affine transform.
`default_nettype none

package iat_pkg;

    localparam int DEFAULT_MAX_DIM = 8;

    localparam int DATA_W    = 32;
    localparam int DIM_W     = 4;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 4;
    localparam int RES_COL_W = 3;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD_T  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_O  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;

    localparam logic [DIM_W-1:0] CFG_RESET = 4'd8;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_BWAIT,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } iat_state_t;

    // Store access: one write port and one read port per store
    typedef struct packed {
        logic               t_we;
        logic               o_we;
        logic [ROW_W-1:0]   w_row;
        logic [COL_W-1:0]   w_col;
        logic [DATA_W-1:0]  w_data;
        logic [ROW_W-1:0]   t_row;
        logic [COL_W-1:0]   t_col;
        logic [ROW_W-1:0]   o_row;
        logic [COL_W-1:0]   o_col;
    } iat_mem_req_t;

    // Multiply-accumulate unit controls
    typedef struct packed {
        logic load_bias;
        logic mul;
        logic acc;
    } iat_mac_ctl_t;

    // Saturate a size register into 1..max_dim
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned max_dim);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(max_dim);
        if (v == '0)
            return DIM_W'(1);
        else if (v > lim)
            return lim;
        else
            return v;
    endfunction

endpackage

`default_nettype wire

### rtl/integer_affine_transform.sv
// Top level of the integer affine transform D = C*A + c.
//
//  channel   direction  handshake               payload
//  cfg       in         cfg_write               cfg_index, cfg_data
//  in        in         in_valid / in_stall     op, row_index, col_index, element
//  out       out        out_valid / out_stall   res_row, res_col, res_value, is_last, status
//
// A load beat writes its store when its indexes are in range; a rejected load emits one status beat.
// A compute beat yields out_rows*out_cols result beats in row-major order: each element
// reads its bias, then steps one product at a time through the read, multiply and
// accumulate states, via the single read port of each store and the one shared multiplier.
// Reset sets every size to 8 and leaves both stores unwritten; no clearing pass.
// A stalled result beat or a running compute stalls the input; a new beat enters once both clear.
`default_nettype none

module integer_affine_transform #(
    parameter int MAX_DIM = iat_pkg::DEFAULT_MAX_DIM
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [iat_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [iat_pkg::DIM_W-1:0]            cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [iat_pkg::OP_W-1:0]             op,
    input  wire logic [iat_pkg::ROW_W-1:0]            row_index,
    input  wire logic [iat_pkg::COL_W-1:0]            col_index,
    input  wire logic signed [iat_pkg::DATA_W-1:0]    element,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [iat_pkg::ROW_W-1:0]                 res_row,
    output logic [iat_pkg::RES_COL_W-1:0]             res_col,
    output logic signed [iat_pkg::DATA_W-1:0]         res_value,
    output logic                                      is_last,
    output logic                                      status
);

    iat_pkg::iat_mem_req_t      req;
    iat_pkg::iat_mac_ctl_t      mac_ctl;
    logic [iat_pkg::DATA_W-1:0] t_rdata;
    logic [iat_pkg::DATA_W-1:0] o_rdata;
    logic [iat_pkg::DATA_W-1:0] acc;
    logic [iat_pkg::DATA_W-1:0] res_value_u;

    // Sequencer and result register
    iat_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .row_index (row_index),
        .col_index (col_index),
        .element   (element),
        .req       (req),
        .mac_ctl   (mac_ctl),
        .acc       (acc),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_row   (res_row),
        .res_col   (res_col),
        .res_value (res_value_u),
        .is_last   (is_last),
        .status    (status)
    );

    // Matrix stores
    iat_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .clk     (clk),
        .req     (req),
        .t_rdata (t_rdata),
        .o_rdata (o_rdata)
    );

    // Shared multiply-accumulate
    iat_mac u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .a   (t_rdata),
        .b   (o_rdata),
        .acc (acc)
    );

    assign res_value = signed'(res_value_u);

endmodule

`default_nettype wire

### rtl/iat_store.sv
// Transform and operand stores, one write and one registered read port each.
`default_nettype none

module iat_store #(
    parameter int MAX_DIM = iat_pkg::DEFAULT_MAX_DIM
) (
    input  wire logic                        clk,
    input  wire iat_pkg::iat_mem_req_t       req,
    output logic [iat_pkg::DATA_W-1:0]       t_rdata,
    output logic [iat_pkg::DATA_W-1:0]       o_rdata
);

    localparam int TSTRIDE = MAX_DIM + 1;
    localparam int T_DEPTH = MAX_DIM * TSTRIDE;
    localparam int O_DEPTH = MAX_DIM * MAX_DIM;
    localparam int TA_W    = (T_DEPTH > 1) ? $clog2(T_DEPTH) : 1;
    localparam int OA_W    = (O_DEPTH > 1) ? $clog2(O_DEPTH) : 1;

    logic [iat_pkg::DATA_W-1:0] tmem [T_DEPTH];
    logic [iat_pkg::DATA_W-1:0] omem [O_DEPTH];

    logic [TA_W-1:0] t_waddr;
    logic [TA_W-1:0] t_raddr;
    logic [OA_W-1:0] o_waddr;
    logic [OA_W-1:0] o_raddr;

    // Map row and column to fixed-stride addresses
    always_comb
    begin
        t_waddr = TA_W'(req.w_row) * TA_W'(TSTRIDE) + TA_W'(req.w_col);
        t_raddr = TA_W'(req.t_row) * TA_W'(TSTRIDE) + TA_W'(req.t_col);
        o_waddr = OA_W'(req.w_row) * OA_W'(MAX_DIM) + OA_W'(req.w_col);
        o_raddr = OA_W'(req.o_row) * OA_W'(MAX_DIM) + OA_W'(req.o_col);
    end

    // Write and read the transform store
    always_ff @(posedge clk)
    begin
        if (req.t_we)
        begin
            tmem[t_waddr] <= req.w_data;
        end
        t_rdata <= tmem[t_raddr];
    end

    // Write and read the operand store
    always_ff @(posedge clk)
    begin
        if (req.o_we)
        begin
            omem[o_waddr] <= req.w_data;
        end
        o_rdata <= omem[o_raddr];
    end

endmodule

`default_nettype wire

### rtl/iat_mac.sv
// Shared multiply-accumulate unit: registered product, then wrapped accumulate.
`default_nettype none

module iat_mac (
    input  wire logic                        clk,
    input  wire iat_pkg::iat_mac_ctl_t       ctl,
    input  wire logic [iat_pkg::DATA_W-1:0]  a,
    input  wire logic [iat_pkg::DATA_W-1:0]  b,
    output logic [iat_pkg::DATA_W-1:0]       acc
);

    logic [iat_pkg::DATA_W-1:0] prod_reg;
    logic [iat_pkg::DATA_W-1:0] prod_next;
    logic [iat_pkg::DATA_W-1:0] acc_reg;
    logic [iat_pkg::DATA_W-1:0] acc_next;

    // Form product and accumulator updates; low word only, so it wraps
    always_comb
    begin
        prod_next = ctl.mul ? (a * b) : prod_reg;
        priority if (ctl.load_bias)
            acc_next = a;
        else if (ctl.acc)
            acc_next = acc_reg + prod_reg;
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

### rtl/iat_ctrl.sv
// Sequencer: configuration, load checks, dot-product stepping and result register.
`default_nettype none

`include "integer_affine_transform_defines.svh"

module iat_ctrl #(
    parameter int MAX_DIM = iat_pkg::DEFAULT_MAX_DIM
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [iat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [iat_pkg::DIM_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [iat_pkg::OP_W-1:0]       op,
    input  wire logic [iat_pkg::ROW_W-1:0]      row_index,
    input  wire logic [iat_pkg::COL_W-1:0]      col_index,
    input  wire logic [iat_pkg::DATA_W-1:0]     element,
    output iat_pkg::iat_mem_req_t               req,
    output iat_pkg::iat_mac_ctl_t               mac_ctl,
    input  wire logic [iat_pkg::DATA_W-1:0]     acc,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [iat_pkg::ROW_W-1:0]           res_row,
    output logic [iat_pkg::RES_COL_W-1:0]       res_col,
    output logic [iat_pkg::DATA_W-1:0]          res_value,
    output logic                                is_last,
    output logic                                status
);

    iat_pkg::iat_state_t state_reg, state_next;

    logic [iat_pkg::DIM_W-1:0] out_rows_reg, out_rows_next;
    logic [iat_pkg::DIM_W-1:0] inner_dim_reg, inner_dim_next;
    logic [iat_pkg::DIM_W-1:0] out_cols_reg, out_cols_next;

    logic [iat_pkg::ROW_W-1:0]     i_reg, i_next;
    logic [iat_pkg::RES_COL_W-1:0] j_reg, j_next;
    logic [iat_pkg::ROW_W-1:0]     k_reg, k_next;

    logic                          out_valid_reg, out_valid_next;
    logic [iat_pkg::ROW_W-1:0]     res_row_reg, res_row_next;
    logic [iat_pkg::RES_COL_W-1:0] res_col_reg, res_col_next;
    logic [iat_pkg::DATA_W-1:0]    res_value_reg, res_value_next;
    logic                          is_last_reg, is_last_next;
    logic                          status_reg, status_next;

    logic [iat_pkg::DIM_W-1:0] nr, ni, nc;
    logic [iat_pkg::DIM_W-1:0] nr_m1, ni_m1, nc_m1;
    logic out_free;
    logic in_accept;
    logic k_last;
    logic j_last;
    logic elem_last;
    logic t_ok;
    logic o_ok;

    // Effective sizes and loop end flags
    always_comb
    begin
        nr        = iat_pkg::clamp_dim(out_rows_reg, MAX_DIM);
        ni        = iat_pkg::clamp_dim(inner_dim_reg, MAX_DIM);
        nc        = iat_pkg::clamp_dim(out_cols_reg, MAX_DIM);
        nr_m1     = nr - iat_pkg::DIM_W'(1);
        ni_m1     = ni - iat_pkg::DIM_W'(1);
        nc_m1     = nc - iat_pkg::DIM_W'(1);
        k_last    = ({1'b0, k_reg} == ni_m1);
        j_last    = ({1'b0, j_reg} == nc_m1);
        elem_last = j_last && ({1'b0, i_reg} == nr_m1);
        t_ok      = ({1'b0, row_index} < nr) && (col_index <= ni);
        o_ok      = ({1'b0, row_index} < ni) && (col_index < nc);
    end

    // Take a new beat only when idle and the result register can accept one
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == iat_pkg::ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;

    // Configuration writes
    always_comb
    begin
        out_rows_next  = out_rows_reg;
        inner_dim_next = inner_dim_reg;
        out_cols_next  = out_cols_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                iat_pkg::CFG_OUT_ROWS:  out_rows_next  = cfg_data;
                iat_pkg::CFG_INNER_DIM: inner_dim_next = cfg_data;
                iat_pkg::CFG_OUT_COLS:  out_cols_next  = cfg_data;
                iat_pkg::CFG_UNUSED:    ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iat_pkg::ST_IDLE:
            begin
                if (in_accept && (op == iat_pkg::OP_COMPUTE))
                    state_next = iat_pkg::ST_BIAS;
            end
            iat_pkg::ST_BIAS:  state_next = iat_pkg::ST_BWAIT;
            iat_pkg::ST_BWAIT: state_next = iat_pkg::ST_READ;
            iat_pkg::ST_READ:  state_next = iat_pkg::ST_MUL;
            iat_pkg::ST_MUL:   state_next = iat_pkg::ST_ACC;
            iat_pkg::ST_ACC:
            begin
                state_next = k_last ? iat_pkg::ST_EMIT : iat_pkg::ST_READ;
            end
            iat_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = elem_last ? iat_pkg::ST_IDLE : iat_pkg::ST_BIAS;
            end
            default: state_next = iat_pkg::ST_IDLE;
        endcase
    end

    // Outputs: store access, unit controls, counters and result register
    always_comb
    begin
        req        = '0;
        req.w_row  = row_index;
        req.w_col  = col_index;
        req.w_data = element;
        req.t_row  = i_reg;
        req.t_col  = (state_reg == iat_pkg::ST_BIAS) ? ni : {1'b0, k_reg};
        req.o_row  = k_reg;
        req.o_col  = {1'b0, j_reg};

        mac_ctl.load_bias = (state_reg == iat_pkg::ST_BWAIT);
        mac_ctl.mul       = (state_reg == iat_pkg::ST_MUL);
        mac_ctl.acc       = (state_reg == iat_pkg::ST_ACC);

        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;

        // Drop the held beat once it is taken
        out_valid_next = out_valid_reg && out_stall;
        res_row_next   = res_row_reg;
        res_col_next   = res_col_reg;
        res_value_next = res_value_reg;
        is_last_next   = is_last_reg;
        status_next    = status_reg;

        unique case (state_reg)
            iat_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (op)
                        iat_pkg::OP_LOAD_T,
                        iat_pkg::OP_LOAD_O:
                        begin
                            if (op == iat_pkg::OP_LOAD_T)
                                req.t_we = t_ok;
                            else
                                req.o_we = o_ok;
                            // Flag a load that falls outside the sizes
                            if ((op == iat_pkg::OP_LOAD_T) ? !t_ok : !o_ok)
                            begin
                                out_valid_next = 1'b1;
                                res_row_next   = '0;
                                res_col_next   = '0;
                                res_value_next = '0;
                                is_last_next   = 1'b1;
                                status_next    = iat_pkg::STATUS_ERR;
                            end
                        end
                        iat_pkg::OP_COMPUTE:
                        begin
                            i_next = '0;
                            j_next = '0;
                        end
                        iat_pkg::OP_NONE: ;
                    endcase
                end
            end
            iat_pkg::ST_BIAS:
            begin
                k_next = '0;
            end
            iat_pkg::ST_BWAIT,
            iat_pkg::ST_READ,
            iat_pkg::ST_MUL: ;
            iat_pkg::ST_ACC:
            begin
                if (!k_last)
                    k_next = k_reg + iat_pkg::ROW_W'(1);
            end
            iat_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    res_row_next   = i_reg;
                    res_col_next   = j_reg;
                    res_value_next = acc;
                    is_last_next   = elem_last;
                    status_next    = iat_pkg::STATUS_OK;
                    // Advance in row-major order
                    if (!elem_last)
                    begin
                        if (j_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + iat_pkg::ROW_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + iat_pkg::RES_COL_W'(1);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iat_pkg::ST_IDLE;
            out_rows_reg  <= iat_pkg::CFG_RESET;
            inner_dim_reg <= iat_pkg::CFG_RESET;
            out_cols_reg  <= iat_pkg::CFG_RESET;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_rows_reg  <= out_rows_next;
            inner_dim_reg <= inner_dim_next;
            out_cols_reg  <= out_cols_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_row_reg   <= res_row_next;
        res_col_reg   <= res_col_next;
        res_value_reg <= res_value_next;
        is_last_reg   <= is_last_next;
        status_reg    <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign res_row   = res_row_reg;
    assign res_col   = res_col_reg;
    assign res_value = res_value_reg;
    assign is_last   = is_last_reg;
    assign status    = status_reg;

    // Checks
    `IAT_ASSERT_NOW(a_store_write_idle, req.t_we || req.o_we, state_reg == iat_pkg::ST_IDLE, "store written outside idle")
    `IAT_ASSERT_NOW(a_k_in_range, state_reg == iat_pkg::ST_ACC, {1'b0, k_reg} < ni, "inner index beyond size")
    `IAT_ASSERT_NOW(a_mul_after_read, state_reg == iat_pkg::ST_MUL, $past(state_reg) == iat_pkg::ST_READ, "product without a read")
    `IAT_ASSERT_NOW(a_emit_in_range, state_reg == iat_pkg::ST_EMIT, ({1'b0, i_reg} < nr) && ({1'b0, j_reg} < nc), "result index beyond size")
    `IAT_ASSERT_NEXT(a_last_to_idle, (state_reg == iat_pkg::ST_EMIT) && out_free && elem_last, (state_reg == iat_pkg::ST_IDLE) && out_valid_reg && is_last_reg, "final element not closing the run")

endmodule

`default_nettype wire

### verif/tb_integer_affine_transform.sv
// Self-checking testbench for the integer affine transform D = C*A + c.
`timescale 1ns / 1ps

module tb_integer_affine_transform;

    localparam int DIM_MAX      = iat_pkg::DEFAULT_MAX_DIM;
    localparam int XSTRIDE      = DIM_MAX + 1;
    localparam int ITEM_TARGET  = 350;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES  = 80;
    localparam int SHOW_LIMIT   = 10;

    // One result element as it leaves the block
    typedef struct packed {
        logic [iat_pkg::ROW_W-1:0]     row;
        logic [iat_pkg::RES_COL_W-1:0] col;
        logic [iat_pkg::DATA_W-1:0]    value;
        logic                          last;
        logic                          status;
    } affine_elem_t;

    typedef enum logic {
        RK_BEAT,
        RK_REG
    } row_kind_t;

    // One line of the directed table
    typedef struct packed {
        row_kind_t                     kind;
        logic [iat_pkg::OP_W-1:0]      opc;
        logic [iat_pkg::ROW_W-1:0]     row;
        logic [iat_pkg::COL_W-1:0]     col;
        logic [iat_pkg::DATA_W-1:0]    word;
        logic                          typed;
        logic [iat_pkg::DATA_W-1:0]    t_value;
        logic                          t_status;
        logic [iat_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [iat_pkg::DIM_W-1:0]     reg_val;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              cfg_write = 1'b0;
    logic [iat_pkg::CFG_IDX_W-1:0]     cfg_index = iat_pkg::CFG_OUT_ROWS;
    logic [iat_pkg::DIM_W-1:0]         cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [iat_pkg::OP_W-1:0]          op = iat_pkg::OP_NONE;
    logic [iat_pkg::ROW_W-1:0]         row_index = '0;
    logic [iat_pkg::COL_W-1:0]         col_index = '0;
    logic signed [iat_pkg::DATA_W-1:0] element = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [iat_pkg::ROW_W-1:0]         res_row;
    logic [iat_pkg::RES_COL_W-1:0]     res_col;
    logic signed [iat_pkg::DATA_W-1:0] res_value;
    logic                              is_last;
    logic                              status;

    // Shadow copy of the block: size registers and both stores
    logic [iat_pkg::DIM_W-1:0]  rows_reg = iat_pkg::CFG_RESET;
    logic [iat_pkg::DIM_W-1:0]  inner_reg = iat_pkg::CFG_RESET;
    logic [iat_pkg::DIM_W-1:0]  cols_reg = iat_pkg::CFG_RESET;
    logic [iat_pkg::DATA_W-1:0] xform_words [DIM_MAX*XSTRIDE];
    logic [iat_pkg::DATA_W-1:0] operand_words [DIM_MAX*DIM_MAX];
    bit                         xform_set [DIM_MAX*XSTRIDE];
    bit                         operand_set [DIM_MAX*DIM_MAX];

    affine_elem_t awaited_elems[$];
    stim_row_t    directed_rows[$];
    int unsigned  items_done = 0;
    int unsigned  n_bad = 0;
    bit           tx_calm = 1'b0;
    bit           rx_calm = 1'b0;

    integer_affine_transform #(
        .MAX_DIM(DIM_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .row_index (row_index),
        .col_index (col_index),
        .element   (element),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_row   (res_row),
        .res_col   (res_col),
        .res_value (res_value),
        .is_last   (is_last),
        .status    (status)
    );

    always #1 clk = ~clk;

    // Saturate a raw size register into 1..DIM_MAX
    function automatic int unsigned eff_dim(input logic [iat_pkg::DIM_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (raw > DIM_MAX)
            return DIM_MAX;
        return 32'(raw);
    endfunction

    // Favor the extremes and small values near zero, otherwise any 32-bit word
    function automatic logic [iat_pkg::DATA_W-1:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return 32'h8000_0000;
        if (roll == 1)
            return 32'h7FFF_FFFF;
        if (roll == 2)
            return 32'($urandom_range(0, 15)) - 32'd8;
        return $urandom;
    endfunction

    // Mostly small sizes, now and then the largest and the out-of-range ones
    function automatic logic [iat_pkg::DIM_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return 4'd0;
        if (roll < 10)
            return 4'd15;
        if (roll < 16)
            return 4'd8;
        if (roll < 22)
            return 4'($urandom_range(5, 7));
        return 4'($urandom_range(1, 3));
    endfunction

    function automatic stim_row_t beat_row(input logic [iat_pkg::OP_W-1:0] opc,
                                           input logic [iat_pkg::ROW_W-1:0] r,
                                           input logic [iat_pkg::COL_W-1:0] c,
                                           input logic [iat_pkg::DATA_W-1:0] w);
        stim_row_t s;
        s = '0;
        s.kind = RK_BEAT;
        s.opc  = opc;
        s.row  = r;
        s.col  = c;
        s.word = w;
        return s;
    endfunction

    // Load whose index is out of range: one status beat
    function automatic stim_row_t fault_row(input logic [iat_pkg::OP_W-1:0] opc,
                                            input logic [iat_pkg::ROW_W-1:0] r,
                                            input logic [iat_pkg::COL_W-1:0] c,
                                            input logic [iat_pkg::DATA_W-1:0] w);
        stim_row_t s;
        s = beat_row(opc, r, c, w);
        s.typed    = 1'b1;
        s.t_value  = '0;
        s.t_status = iat_pkg::STATUS_ERR;
        return s;
    endfunction

    // Compute at 1x1x1: a single element, known by hand
    function automatic stim_row_t sum_row(input logic [iat_pkg::DATA_W-1:0] v);
        stim_row_t s;
        s = beat_row(iat_pkg::OP_COMPUTE, '0, '0, $urandom);
        s.typed    = 1'b1;
        s.t_value  = v;
        s.t_status = iat_pkg::STATUS_OK;
        return s;
    endfunction

    function automatic stim_row_t reg_row(input logic [iat_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [iat_pkg::DIM_W-1:0] val);
        stim_row_t s;
        s = '0;
        s.kind    = RK_REG;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    // Work out what one accepted beat does to the stores and what it emits
    task automatic apply_affine_item(input logic [iat_pkg::OP_W-1:0] opc,
                                     input logic [iat_pkg::ROW_W-1:0] r,
                                     input logic [iat_pkg::COL_W-1:0] c,
                                     input logic [iat_pkg::DATA_W-1:0] w,
                                     input bit emit_it);
        int unsigned  nr, ni, nc, i, j, k;
        logic [iat_pkg::DATA_W-1:0] acc;
        affine_elem_t fault;
        nr = eff_dim(rows_reg);
        ni = eff_dim(inner_reg);
        nc = eff_dim(cols_reg);
        fault = '{'0, '0, '0, 1'b1, iat_pkg::STATUS_ERR};
        case (opc)
            iat_pkg::OP_LOAD_T:
            begin
                if (r < nr && c <= ni)
                begin
                    xform_words[r*XSTRIDE + c] = w;
                    xform_set[r*XSTRIDE + c] = 1'b1;
                end
                else if (emit_it)
                    awaited_elems.push_back(fault);
            end
            iat_pkg::OP_LOAD_O:
            begin
                if (r < ni && c < nc)
                begin
                    operand_words[r*DIM_MAX + c] = w;
                    operand_set[r*DIM_MAX + c] = 1'b1;
                end
                else if (emit_it)
                    awaited_elems.push_back(fault);
            end
            iat_pkg::OP_COMPUTE:
            begin
                // Bias first, then the dot product, wrapping at 32 bits
                for (i = 0; i < nr && emit_it; i++)
                begin
                    for (j = 0; j < nc; j++)
                    begin
                        acc = xform_words[i*XSTRIDE + ni];
                        for (k = 0; k < ni; k++)
                            acc = acc + xform_words[i*XSTRIDE + k] *
                                        operand_words[k*DIM_MAX + j];
                        awaited_elems.push_back('{3'(i), 3'(j), acc,
                                                  (i + 1 == nr && j + 1 == nc),
                                                  iat_pkg::STATUS_OK});
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Present one beat after a random gap, hold it until accepted
    task automatic send_beat(input logic [iat_pkg::OP_W-1:0] opc,
                             input logic [iat_pkg::ROW_W-1:0] r,
                             input logic [iat_pkg::COL_W-1:0] c,
                             input logic [iat_pkg::DATA_W-1:0] w);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= opc;
        row_index <= r;
        col_index <= c;
        element   <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic issue_item(input logic [iat_pkg::OP_W-1:0] opc,
                              input logic [iat_pkg::ROW_W-1:0] r,
                              input logic [iat_pkg::COL_W-1:0] c,
                              input logic [iat_pkg::DATA_W-1:0] w);
        send_beat(opc, r, c, w);
        apply_affine_item(opc, r, c, w, 1'b1);
        if (opc != iat_pkg::OP_NONE)
            items_done++;
    endtask

    // Random op other than compute, random indexes: mostly dropped loads
    task automatic issue_noise();
        logic [iat_pkg::OP_W-1:0] opc;
        opc = 2'($urandom_range(0, 2));
        if (opc == iat_pkg::OP_COMPUTE)
            opc = iat_pkg::OP_NONE;
        issue_item(opc, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), pick_word());
    endtask

    task automatic hold_input();
        in_valid <= 1'b0;
    endtask

    // Wait until every expected beat is in, then let a trailing load finish
    task automatic drain_results();
        @(posedge clk);
        while (awaited_elems.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [iat_pkg::CFG_IDX_W-1:0] idx,
                             input logic [iat_pkg::DIM_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == iat_pkg::CFG_OUT_ROWS)
            rows_reg = val;
        else if (idx == iat_pkg::CFG_INNER_DIM)
            inner_reg = val;
        else if (idx == iat_pkg::CFG_OUT_COLS)
            cols_reg = val;
    endtask

    // Receiver: stall a random count before each beat, with calm stretches
    initial
    begin
        int unsigned hold;
        forever
        begin
            if ($urandom_range(0, 11) == 0)
                rx_calm = !rx_calm;
            hold = rx_calm ? 0 : $urandom_range(0, 17);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin : check_beat
        affine_elem_t got;
        affine_elem_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{res_row, res_col, res_value, is_last, status};
            if (awaited_elems.size() == 0)
            begin
                n_bad++;
                if (n_bad <= SHOW_LIMIT)
                    $display("unexpected beat: row %0d col %0d value %h last %0b status %0b",
                             got.row, got.col, got.value, got.last, got.status);
            end
            else
            begin
                want = awaited_elems.pop_front();
                if (got !== want)
                begin
                    n_bad++;
                    if (n_bad <= SHOW_LIMIT)
                        $display("mismatch: expected row %0d col %0d value %h last %0b status %0b",
                                 want.row, want.col, want.value, want.last, want.status);
                    if (n_bad <= SHOW_LIMIT)
                        $display("          got      row %0d col %0d value %h last %0b status %0b",
                                 got.row, got.col, got.value, got.last, got.status);
                end
            end
        end
    end

    // Stimulus: directed table, then random phases of loads and computes
    initial
    begin
        int unsigned nr, ni, nc, i, k, r, c;
        stim_row_t   s;

        // Reset sizes are 8: out-of-range loads, loads at the far corners, unused op
        directed_rows.push_back(fault_row(iat_pkg::OP_LOAD_T, 3'd7, 4'd9, 32'h0000_0000));
        directed_rows.push_back(fault_row(iat_pkg::OP_LOAD_T, 3'd7, 4'd15, 32'hFFFF_FFFF));
        directed_rows.push_back(fault_row(iat_pkg::OP_LOAD_O, 3'd7, 4'd8, 32'h8000_0000));
        directed_rows.push_back(fault_row(iat_pkg::OP_LOAD_O, 3'd0, 4'd15, 32'h7FFF_FFFF));
        directed_rows.push_back(beat_row(iat_pkg::OP_LOAD_T, 3'd7, 4'd8, 32'h7FFF_FFFF));
        directed_rows.push_back(beat_row(iat_pkg::OP_LOAD_O, 3'd7, 4'd7, 32'h8000_0000));
        directed_rows.push_back(beat_row(iat_pkg::OP_NONE, 3'd7, 4'd15, 32'hFFFF_FFFF));
        // 1x1x1: most negative times minus one wraps, minus one more gives max
        directed_rows.push_back(reg_row(iat_pkg::CFG_OUT_ROWS, 4'd1));
        directed_rows.push_back(reg_row(iat_pkg::CFG_INNER_DIM, 4'd1));
        directed_rows.push_back(reg_row(iat_pkg::CFG_OUT_COLS, 4'd1));
        directed_rows.push_back(beat_row(iat_pkg::OP_LOAD_T, 3'd0, 4'd0, 32'h8000_0000));
        directed_rows.push_back(beat_row(iat_pkg::OP_LOAD_T, 3'd0, 4'd1, 32'hFFFF_FFFF));
        directed_rows.push_back(beat_row(iat_pkg::OP_LOAD_O, 3'd0, 4'd0, 32'hFFFF_FFFF));
        directed_rows.push_back(sum_row(32'h7FFF_FFFF));
        directed_rows.push_back(fault_row(iat_pkg::OP_LOAD_T, 3'd1, 4'd0, 32'h1234_5678));
        directed_rows.push_back(fault_row(iat_pkg::OP_LOAD_T, 3'd0, 4'd2, 32'h1234_5678));
        directed_rows.push_back(fault_row(iat_pkg::OP_LOAD_O, 3'd1, 4'd0, 32'h1234_5678));
        directed_rows.push_back(fault_row(iat_pkg::OP_LOAD_O, 3'd0, 4'd1, 32'h1234_5678));
        // Sizes of zero act as one; the unused register index changes nothing
        directed_rows.push_back(reg_row(iat_pkg::CFG_OUT_ROWS, 4'd0));
        directed_rows.push_back(reg_row(iat_pkg::CFG_INNER_DIM, 4'd0));
        directed_rows.push_back(reg_row(iat_pkg::CFG_OUT_COLS, 4'd0));
        directed_rows.push_back(reg_row(iat_pkg::CFG_UNUSED, 4'd15));
        directed_rows.push_back(sum_row(32'h7FFF_FFFF));
        directed_rows.push_back(beat_row(iat_pkg::OP_LOAD_O, 3'd0, 4'd0, 32'h0000_0000));
        directed_rows.push_back(sum_row(32'hFFFF_FFFF));
        // Sizes above the maximum saturate to 8
        directed_rows.push_back(reg_row(iat_pkg::CFG_OUT_ROWS, 4'd15));
        directed_rows.push_back(reg_row(iat_pkg::CFG_INNER_DIM, 4'd15));
        directed_rows.push_back(reg_row(iat_pkg::CFG_OUT_COLS, 4'd15));
        directed_rows.push_back(fault_row(iat_pkg::OP_LOAD_T, 3'd7, 4'd9, 32'h5555_5555));
        directed_rows.push_back(beat_row(iat_pkg::OP_LOAD_T, 3'd7, 4'd8, 32'hAAAA_AAAA));
        directed_rows.push_back(fault_row(iat_pkg::OP_LOAD_O, 3'd7, 4'd8, 32'h5555_5555));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[n])
        begin
            s = directed_rows[n];
            if (s.kind == RK_REG)
            begin
                hold_input();
                drain_results();
                write_reg(s.reg_idx, s.reg_val);
            end
            else
            begin
                send_beat(s.opc, s.row, s.col, s.word);
                apply_affine_item(s.opc, s.row, s.col, s.word, !s.typed);
                if (s.typed)
                    awaited_elems.push_back('{'0, '0, s.t_value, 1'b1, s.t_status});
                if (s.opc != iat_pkg::OP_NONE)
                    items_done++;
            end
        end

        // Random phases: new sizes, refresh and fill the stores, then compute
        while (items_done < ITEM_TARGET)
        begin
            hold_input();
            drain_results();
            write_reg(iat_pkg::CFG_OUT_ROWS, pick_size());
            write_reg(iat_pkg::CFG_INNER_DIM, pick_size());
            write_reg(iat_pkg::CFG_OUT_COLS, pick_size());
            if ($urandom_range(0, 7) == 0)
                write_reg(iat_pkg::CFG_UNUSED, 4'($urandom_range(0, 15)));
            nr = eff_dim(rows_reg);
            ni = eff_dim(inner_reg);
            nc = eff_dim(cols_reg);
            tx_calm = ($urandom_range(0, 3) == 0);

            repeat ($urandom_range(1, 2))
            begin
                // Overwrite a few in-range entries with fresh values
                repeat ($urandom_range(0, 4))
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        r = $urandom_range(0, nr - 1);
                        c = $urandom_range(0, ni);
                        issue_item(iat_pkg::OP_LOAD_T, 3'(r), 4'(c), pick_word());
                    end
                    else
                    begin
                        r = $urandom_range(0, ni - 1);
                        c = $urandom_range(0, nc - 1);
                        issue_item(iat_pkg::OP_LOAD_O, 3'(r), 4'(c), pick_word());
                    end
                end

                // Write every entry the compute reads that is still unwritten
                for (i = 0; i < nr; i++)
                begin
                    for (k = 0; k <= ni; k++)
                    begin
                        if (!xform_set[i*XSTRIDE + k])
                        begin
                            if ($urandom_range(0, 7) == 0)
                                issue_noise();
                            issue_item(iat_pkg::OP_LOAD_T, 3'(i), 4'(k), pick_word());
                        end
                    end
                end
                for (k = 0; k < ni; k++)
                begin
                    for (i = 0; i < nc; i++)
                    begin
                        if (!operand_set[k*DIM_MAX + i])
                        begin
                            if ($urandom_range(0, 7) == 0)
                                issue_noise();
                            issue_item(iat_pkg::OP_LOAD_O, 3'(k), 4'(i), pick_word());
                        end
                    end
                end
                repeat ($urandom_range(0, 2))
                    issue_noise();

                // Now and then pause until the block has emitted everything
                if ($urandom_range(0, 5) == 0)
                begin
                    hold_input();
                    drain_results();
                end
                issue_item(iat_pkg::OP_COMPUTE, 3'($urandom_range(0, 7)),
                           4'($urandom_range(0, 15)), pick_word());
            end
        end

        // Drain and report
        hold_input();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_bad == 0 && awaited_elems.size() == 0)
            $display("** integer_affine_transform: PASSED **");
        else
            $display("** integer_affine_transform: FAILED **");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #10_000_000;
        $display("** integer_affine_transform: FAILED **");
        $finish;
    end

endmodule
